// ----- sv/nnfu_pkg.sv -----
// Shared constants, types and helper functions for the nearest-neighbor frame upscaler.
// No dependencies; every other file of the block but nnfu_ram refers to this package by scoped names.

package nnfu_pkg;

   // Default source frame geometry.
   localparam int SRC_WIDTH_DEF  = 320;
   localparam int SRC_HEIGHT_DEF = 200;

   // Field and register widths.
   localparam int CFG_W      = 11;
   localparam int DIM_W      = 10;
   localparam int PIX_W      = 16;
   localparam int COL_IN_W   = 9;
   localparam int ROW_IN_W   = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Largest destination size in either direction.
   localparam logic [CFG_W-1:0] DEST_MAX = 11'd1024;

   // Register reset values.
   localparam logic [CFG_W-1:0] DEST_WIDTH_RST  = 11'd800;
   localparam logic [CFG_W-1:0] DEST_HEIGHT_RST = 11'd480;

   // Register indexes, decoded from the word address.
   localparam logic REG_DEST_WIDTH  = 1'b0;
   localparam logic REG_DEST_HEIGHT = 1'b1;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // Configuration handed from the register file to the scan generator.
   typedef struct packed {
      logic [CFG_W-1:0] dest_width;
      logic [CFG_W-1:0] dest_height;
      logic             restart;
   } csr_cfg_type;

   // Destination position of the pixel currently being fetched.
   typedef struct packed {
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] row;
      logic             frame_end;
   } scan_pos_type;

   // Raise a destination size to the source size and saturate it at the maximum.
   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] reg_val,
                                                 input logic [CFG_W-1:0] src_val);
      logic [CFG_W-1:0] s;
      s = reg_val;
      if (s < src_val) begin
         s = src_val;
      end
      if (s > DEST_MAX) begin
         s = DEST_MAX;
      end
      return s;
   endfunction

   // Swap the two bytes of a pixel.
   function automatic logic [PIX_W-1:0] byte_swap(input logic [PIX_W-1:0] v);
      return {v[7:0], v[15:8]};
   endfunction

endpackage

// ----- sv/nnfu_req_if.sv -----
// Command channel of the frame upscaler: valid/ready handshake with the command payload.
// Depends on nnfu_pkg for field widths.

interface nnfu_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [nnfu_pkg::COL_IN_W-1:0] src_col;
   logic [nnfu_pkg::ROW_IN_W-1:0] src_row;
   logic [nnfu_pkg::PIX_W-1:0]    pixel_in;

   modport source (output valid, command, src_col, src_row, pixel_in, input ready);
   modport sink   (input valid, command, src_col, src_row, pixel_in, output ready);
endinterface

// ----- sv/nnfu_rsp_if.sv -----
// Result channel of the frame upscaler: valid/ready handshake with the pixel payload.
// Depends on nnfu_pkg for field widths.

interface nnfu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nnfu_pkg::PIX_W-1:0] pixel_out;
   logic [nnfu_pkg::DIM_W-1:0] dest_col;
   logic [nnfu_pkg::DIM_W-1:0] dest_row;
   logic                       frame_end;

   modport source (output valid, pixel_out, dest_col, dest_row, frame_end, input ready);
   modport sink   (input valid, pixel_out, dest_col, dest_row, frame_end, output ready);
endinterface

// ----- sv/nnfu_ram.sv -----
// Generic single-port RAM with registered read data; read data holds when no read is issued.
// No dependencies.

module nnfu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access per cycle: a write or a read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/nnfu_csr.sv -----
// APB-style register file holding the destination width and height.
// Depends on nnfu_pkg for widths, reset values, register indexes and the config struct.

module nnfu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nnfu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nnfu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nnfu_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output nnfu_pkg::csr_cfg_type            cfg
);

   logic [nnfu_pkg::CFG_W-1:0] dest_width_ff;
   logic [nnfu_pkg::CFG_W-1:0] dest_height_ff;
   logic                       wr_stb;
   logic                       reg_idx;
   logic [nnfu_pkg::CFG_W-1:0] rd_val;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff  <= nnfu_pkg::DEST_WIDTH_RST;
         dest_height_ff <= nnfu_pkg::DEST_HEIGHT_RST;
      end else begin
         if (wr_stb) begin
            unique case (reg_idx)
               nnfu_pkg::REG_DEST_WIDTH: begin
                  dest_width_ff <= csr_pwdata[nnfu_pkg::CFG_W-1:0];
               end
               nnfu_pkg::REG_DEST_HEIGHT: begin
                  dest_height_ff <= csr_pwdata[nnfu_pkg::CFG_W-1:0];
               end
            endcase
         end
      end
   end

   // Read-back of the raw register values.
   always_comb begin
      unique case (reg_idx)
         nnfu_pkg::REG_DEST_WIDTH:  rd_val = dest_width_ff;
         nnfu_pkg::REG_DEST_HEIGHT: rd_val = dest_height_ff;
      endcase
   end

   assign csr_prdata = nnfu_pkg::CSR_DATA_W'(rd_val);

   // Any register write restarts the destination frame at the same clock edge.
   assign cfg.dest_width  = dest_width_ff;
   assign cfg.dest_height = dest_height_ff;
   assign cfg.restart     = wr_stb;

endmodule

// ----- sv/nnfu_scan.sv -----
// Destination raster scan with DDA accumulators that map each destination pixel to a source
// address. Depends on nnfu_pkg for widths, the config struct and the size clamp.

module nnfu_scan #(
   parameter int SRC_WIDTH  = nnfu_pkg::SRC_WIDTH_DEF,
   parameter int SRC_HEIGHT = nnfu_pkg::SRC_HEIGHT_DEF,
   localparam int ADDR_W    = $clog2(SRC_WIDTH * SRC_HEIGHT),
   localparam int MCOL_W    = $clog2(SRC_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nnfu_pkg::csr_cfg_type  cfg,
   input  logic                   step,
   output nnfu_pkg::scan_pos_type pos,
   output logic [ADDR_W-1:0]      rd_addr
);

   localparam logic [nnfu_pkg::CFG_W-1:0] SRC_W_C = nnfu_pkg::CFG_W'(SRC_WIDTH);
   localparam logic [nnfu_pkg::CFG_W-1:0] SRC_H_C = nnfu_pkg::CFG_W'(SRC_HEIGHT);

   logic [nnfu_pkg::DIM_W-1:0] col_ff, col_in;
   logic [nnfu_pkg::DIM_W-1:0] row_ff, row_in;
   logic [nnfu_pkg::CFG_W-1:0] col_acc_ff, col_acc_in;
   logic [nnfu_pkg::CFG_W-1:0] row_acc_ff, row_acc_in;
   logic [MCOL_W-1:0]          map_col_ff, map_col_in;
   logic [ADDR_W-1:0]          row_base_ff, row_base_in;

   logic [nnfu_pkg::CFG_W-1:0] eff_w;
   logic [nnfu_pkg::CFG_W-1:0] eff_h;
   logic [nnfu_pkg::CFG_W-1:0] col_step;
   logic [nnfu_pkg::CFG_W-1:0] row_step;
   logic                       last_col;
   logic                       last_row;

   assign eff_w = nnfu_pkg::eff_size(cfg.dest_width, SRC_W_C);
   assign eff_h = nnfu_pkg::eff_size(cfg.dest_height, SRC_H_C);

   assign last_col = ({1'b0, col_ff} + 11'd1) == eff_w;
   assign last_row = ({1'b0, row_ff} + 11'd1) == eff_h;
   assign col_step = col_acc_ff + SRC_W_C;
   assign row_step = row_acc_ff + SRC_H_C;

   // Next position: advance along the row, wrap to the next line, wrap to the frame start.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      col_acc_in  = col_acc_ff;
      row_acc_in  = row_acc_ff;
      map_col_in  = map_col_ff;
      row_base_in = row_base_ff;
      if (!last_col) begin
         col_in = col_ff + 10'd1;
         if (col_step >= eff_w) begin
            col_acc_in = col_step - eff_w;
            map_col_in = map_col_ff + MCOL_W'(1);
         end else begin
            col_acc_in = col_step;
         end
      end else begin
         col_in     = '0;
         col_acc_in = '0;
         map_col_in = '0;
         if (!last_row) begin
            row_in = row_ff + 10'd1;
            if (row_step >= eff_h) begin
               row_acc_in  = row_step - eff_h;
               row_base_in = row_base_ff + ADDR_W'(SRC_WIDTH);
            end else begin
               row_acc_in = row_step;
            end
         end else begin
            row_in      = '0;
            row_acc_in  = '0;
            row_base_in = '0;
         end
      end
   end

   // Position registers; a register write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         col_ff      <= '0;
         row_ff      <= '0;
         col_acc_ff  <= '0;
         row_acc_ff  <= '0;
         map_col_ff  <= '0;
         row_base_ff <= '0;
      end else if (step) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_acc_ff  <= col_acc_in;
         row_acc_ff  <= row_acc_in;
         map_col_ff  <= map_col_in;
         row_base_ff <= row_base_in;
      end
   end

   assign pos.col       = col_ff;
   assign pos.row       = row_ff;
   assign pos.frame_end = last_col && last_row;
   assign rd_addr       = row_base_ff + ADDR_W'(map_col_ff);

endmodule

// ----- sv/nearest_neighbor_frame_upscaler.sv -----
// Nearest-neighbor frame upscaler for RGB565 pixels with a single-port frame store.
// A fetch transfer's result passes through the frame store read and then the output register.
// Throughput: one command per cycle, writes and fetches alike, while the result side does not stall.
// Reset is synchronous and clears the scan position and the pipeline valid flags, and loads
// the size registers with 800 and 480; the frame store is not cleared.

module nearest_neighbor_frame_upscaler #(
   parameter int SRC_WIDTH  = nnfu_pkg::SRC_WIDTH_DEF,
   parameter int SRC_HEIGHT = nnfu_pkg::SRC_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   nnfu_req_if.sink                        req_chan,
   nnfu_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nnfu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nnfu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nnfu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int STORE_DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   nnfu_pkg::csr_cfg_type  cfg;
   nnfu_pkg::scan_pos_type scan_pos;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      ram_addr;
   logic [nnfu_pkg::PIX_W-1:0] ram_rdata;

   logic accept;
   logic fetch;
   logic wr_ok;
   logic store_wr;
   logic out_free;
   logic s1_adv;

   logic                   s1_valid_ff, s1_valid_in;
   nnfu_pkg::scan_pos_type s1_pos_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [nnfu_pkg::PIX_W-1:0] out_pixel_ff;
   nnfu_pkg::scan_pos_type out_pos_ff;

   nnfu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: the read stage frees up when the output register can take its pixel.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign fetch          = accept && (req_chan.command == nnfu_pkg::CMD_FETCH);

   // Source pixel writes outside the frame are dropped.
   assign wr_ok    = ({2'b00, req_chan.src_col} < nnfu_pkg::CFG_W'(SRC_WIDTH))
                     && ({3'b000, req_chan.src_row} < nnfu_pkg::CFG_W'(SRC_HEIGHT));
   assign store_wr = accept && (req_chan.command == nnfu_pkg::CMD_WRITE) && wr_ok;
   assign wr_addr  = ADDR_W'(req_chan.src_row) * ADDR_W'(SRC_WIDTH)
                     + ADDR_W'(req_chan.src_col);
   assign ram_addr = store_wr ? wr_addr : rd_addr;

   nnfu_scan #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (fetch),
      .pos     (scan_pos),
      .rd_addr (rd_addr)
   );

   nnfu_ram #(
      .WIDTH (nnfu_pkg::PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .rd_en   (fetch),
      .addr    (ram_addr),
      .wr_data (req_chan.pixel_in),
      .rd_data (ram_rdata)
   );

   // Valid flags of the read stage and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (fetch) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: position travels alongside the store read.
   always_ff @(posedge clock) begin
      if (fetch) begin
         s1_pos_ff <= scan_pos;
      end
      if (s1_adv) begin
         out_pixel_ff <= nnfu_pkg::byte_swap(ram_rdata);
         out_pos_ff   <= s1_pos_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pixel_out = out_pixel_ff;
   assign rsp_chan.dest_col  = out_pos_ff.col;
   assign rsp_chan.dest_row  = out_pos_ff.row;
   assign rsp_chan.frame_end = out_pos_ff.frame_end;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_frame_upscaler: a scoreboard tracks the frame
// store and the scan position, and tasks drive the command and register ports.
// Depends on nnfu_pkg, nnfu_req_if, nnfu_rsp_if and the upscaler RTL.

module tb_top;

   localparam int SRC_W         = nnfu_pkg::SRC_WIDTH_DEF;
   localparam int SRC_H         = nnfu_pkg::SRC_HEIGHT_DEF;
   localparam int SRC_PIXELS    = SRC_W * SRC_H;
   localparam int NOISE_PCT     = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 2000;

   // One destination pixel as it leaves the block.
   typedef struct packed {
      logic [nnfu_pkg::PIX_W-1:0] pixel;
      logic [nnfu_pkg::DIM_W-1:0] col;
      logic [nnfu_pkg::DIM_W-1:0] row;
      logic                       frame_end;
   } pixel_result_type;

   // Scoreboard: mirrors the frame store and the DDA scan, and queues the pixels due out.
   class pixel_scoreboard;
      bit [nnfu_pkg::PIX_W-1:0] src_pixels [SRC_PIXELS];
      bit [nnfu_pkg::CFG_W-1:0] width_reg;
      bit [nnfu_pkg::CFG_W-1:0] height_reg;
      bit [nnfu_pkg::DIM_W-1:0] col_count;
      bit [nnfu_pkg::DIM_W-1:0] row_count;
      bit [nnfu_pkg::CFG_W-1:0] col_acc;
      bit [nnfu_pkg::CFG_W-1:0] row_acc;
      bit [nnfu_pkg::COL_IN_W-1:0] map_col;
      bit [nnfu_pkg::ROW_IN_W-1:0] map_row;
      pixel_result_type pending[$];
      int mismatches;
      int frame_ends;

      function new();
         width_reg  = nnfu_pkg::DEST_WIDTH_RST;
         height_reg = nnfu_pkg::DEST_HEIGHT_RST;
         mismatches = 0;
         frame_ends = 0;
         restart_scan();
      endfunction

      function void restart_scan();
         col_count = '0;
         row_count = '0;
         col_acc   = '0;
         row_acc   = '0;
         map_col   = '0;
         map_row   = '0;
      endfunction

      // A destination size never drops below the source size nor exceeds the maximum.
      function int clamp_size(bit [nnfu_pkg::CFG_W-1:0] val, int src);
         int s;
         s = val;
         if (s < src) s = src;
         if (s > int'(nnfu_pkg::DEST_MAX)) s = int'(nnfu_pkg::DEST_MAX);
         return s;
      endfunction

      function void set_size(logic idx, bit [nnfu_pkg::CFG_W-1:0] val);
         if (idx == nnfu_pkg::REG_DEST_WIDTH) width_reg = val;
         else height_reg = val;
         restart_scan();
      endfunction

      // Store entry that the next fetch will read.
      function int next_index();
         if (col_count >= clamp_size(width_reg, SRC_W) ||
             row_count >= clamp_size(height_reg, SRC_H)) return 0;
         return int'(map_row) * SRC_W + int'(map_col);
      endfunction

      function void note_request(logic cmd, logic [nnfu_pkg::COL_IN_W-1:0] col,
                                 logic [nnfu_pkg::ROW_IN_W-1:0] row,
                                 logic [nnfu_pkg::PIX_W-1:0] pix);
         int w;
         int h;
         bit [nnfu_pkg::PIX_W-1:0] v;
         bit last_col;
         bit last_row;
         pixel_result_type res;
         if (cmd == nnfu_pkg::CMD_WRITE) begin
            // Writes outside the source frame leave the store alone.
            if (col < SRC_W && row < SRC_H) src_pixels[int'(row) * SRC_W + int'(col)] = pix;
            return;
         end
         w = clamp_size(width_reg, SRC_W);
         h = clamp_size(height_reg, SRC_H);
         if (col_count >= w || row_count >= h) restart_scan();
         v = src_pixels[int'(map_row) * SRC_W + int'(map_col)];
         last_col = (int'(col_count) + 1 == w);
         last_row = (int'(row_count) + 1 == h);
         res.pixel     = {v[7:0], v[15:8]};
         res.col       = col_count;
         res.row       = row_count;
         res.frame_end = last_col && last_row;
         if (res.frame_end) frame_ends++;
         pending.push_back(res);
         // Step the DDA: the source position advances each time the remainder wraps.
         if (!last_col) begin
            col_count++;
            col_acc += SRC_W;
            if (col_acc >= w) begin
               col_acc -= w;
               map_col++;
            end
         end else begin
            col_count = '0;
            col_acc   = '0;
            map_col   = '0;
            if (!last_row) begin
               row_count++;
               row_acc += SRC_H;
               if (row_acc >= h) begin
                  row_acc -= h;
                  map_row++;
               end
            end else begin
               row_count = '0;
               row_acc   = '0;
               map_row   = '0;
            end
         end
      endfunction

      function void check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected pixel %h at col %0d row %0d", $time, got.pixel, got.col,
                     got.row);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_out expected %h got %h", $time, want.pixel, got.pixel);
            mismatches++;
         end
         if (got.col !== want.col) begin
            $display("%0t: dest_col expected %0d got %0d", $time, want.col, got.col);
            mismatches++;
         end
         if (got.row !== want.row) begin
            $display("%0t: dest_row expected %0d got %0d", $time, want.row, got.row);
            mismatches++;
         end
         if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b got %b", $time, want.frame_end, got.frame_end);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [nnfu_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [nnfu_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [nnfu_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   nnfu_req_if req_bus ();
   nnfu_rsp_if rsp_bus ();

   pixel_scoreboard sb;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int filled          = 0;   // store entries below this raster index are known written
   int quiet_cycles    = 0;

   nearest_neighbor_frame_upscaler #(
      .SRC_WIDTH (SRC_W),
      .SRC_HEIGHT(SRC_H)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every result transfer is checked against the oldest queued pixel.
   always @(posedge clock) begin : rsp_monitor
      pixel_result_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.pixel     = rsp_bus.pixel_out;
         seen.col       = rsp_bus.dest_col;
         seen.row       = rsp_bus.dest_row;
         seen.frame_end = rsp_bus.frame_end;
         sb.check_pixel(seen);
      end
   end

   // Watchdog: too long without any transfer means the block is hung.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // One command transfer, possibly preceded by a random idle gap.
   task automatic send_request(input logic cmd, input logic [nnfu_pkg::COL_IN_W-1:0] col,
                               input logic [nnfu_pkg::ROW_IN_W-1:0] row,
                               input logic [nnfu_pkg::PIX_W-1:0] pix);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.src_col  <= col;
      req_bus.src_row  <= row;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(cmd, col, row, pix);
   endtask

   task automatic send_fetch();
      send_request(nnfu_pkg::CMD_FETCH, 9'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // Write the first store entry not yet known to be written.
   task automatic write_frontier(input logic [nnfu_pkg::PIX_W-1:0] pix);
      send_request(nnfu_pkg::CMD_WRITE, 9'(filled % SRC_W), 8'(filled / SRC_W), pix);
      filled++;
   endtask

   // One random command; counted is low for writes that fall outside the frame.
   task automatic issue_random(input int fetch_pct, output bit counted);
      int pick;
      int slot;
      pick    = $urandom_range(99);
      counted = 1'b1;
      if (pick < NOISE_PCT) begin
         counted = 1'b0;
         if ($urandom_range(1) == 1)
            send_request(nnfu_pkg::CMD_WRITE, 9'($urandom_range(511, SRC_W)), 8'($urandom),
                         16'($urandom));
         else
            send_request(nnfu_pkg::CMD_WRITE, 9'($urandom), 8'($urandom_range(255, SRC_H)),
                         16'($urandom));
      end else if (pick < NOISE_PCT + fetch_pct && sb.next_index() < filled) begin
         send_fetch();
      end else if (filled == SRC_PIXELS || (filled > 0 && $urandom_range(3) == 0)) begin
         slot = $urandom_range(filled - 1);
         send_request(nnfu_pkg::CMD_WRITE, 9'(slot % SRC_W), 8'(slot / SRC_W), 16'($urandom));
      end else begin
         write_frontier(16'($urandom));
      end
   endtask

   // Close the command stream, wait for every queued pixel, then let the clock run on idle.
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transfer: setup phase, then access until pready.
   task automatic csr_access(input logic idx, input logic wr,
                             input logic [nnfu_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [nnfu_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write a size register, then read it back.
   task automatic set_size(input logic idx, input logic [nnfu_pkg::CFG_W-1:0] val);
      logic [nnfu_pkg::CSR_DATA_W-1:0] rd;
      csr_access(idx, 1'b1, nnfu_pkg::CSR_DATA_W'(val), rd);
      sb.set_size(idx, val);
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== nnfu_pkg::CSR_DATA_W'(val)) begin
         $display("%0t: register %0d read expected %h got %h", $time, idx, val, rd);
         sb.mismatches++;
      end
   endtask

   // A phase: new sizes, optionally run through whole frames, then random traffic.
   task automatic run_phase(input int idle, input int stall,
                            input logic [nnfu_pkg::CFG_W-1:0] w,
                            input logic [nnfu_pkg::CFG_W-1:0] h,
                            input int items, input int fetch_pct, input int frames);
      int goal;
      int n;
      bit counted;
      sender_idle_pct = idle;
      rsp_stall_pct   = stall;
      set_size(nnfu_pkg::REG_DEST_WIDTH, w);
      set_size(nnfu_pkg::REG_DEST_HEIGHT, h);
      goal = sb.frame_ends + frames;
      while (sb.frame_ends < goal) issue_random(fetch_pct, counted);
      n = 0;
      while (n < items) begin
         issue_random(fetch_pct, counted);
         if (counted) n++;
      end
      wait_drain();
   endtask

   initial begin
      sb = new();
      req_bus.valid    = 1'b0;
      req_bus.command  = nnfu_pkg::CMD_WRITE;
      req_bus.src_col  = '0;
      req_bus.src_row  = '0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: writes outside the frame, the far corner, pixel extremes, and fetches at the
      // reset sizes.
      send_request(nnfu_pkg::CMD_WRITE, 9'd320, 8'd0, 16'hFFFF);
      send_request(nnfu_pkg::CMD_WRITE, 9'd511, 8'd255, 16'hFFFF);
      send_request(nnfu_pkg::CMD_WRITE, 9'd0, 8'd200, 16'h1234);
      send_request(nnfu_pkg::CMD_WRITE, 9'd319, 8'd199, 16'h8001);
      write_frontier(16'hFFFF);
      write_frontier(16'h0000);
      write_frontier(16'h00FF);
      write_frontier(16'hFF00);
      repeat (6) send_fetch();
      send_request(nnfu_pkg::CMD_WRITE, 9'd0, 8'd0, 16'hA55A);
      wait_drain();
      // A register write mid-frame restarts the scan at the frame origin.
      set_size(nnfu_pkg::REG_DEST_WIDTH, nnfu_pkg::DEST_WIDTH_RST);
      repeat (3) send_fetch();
      wait_drain();

      // Random phases over the idling patterns and the size extremes, clamped ones included.
      run_phase(0, 0, 11'd320, 11'd200, 110, 50, 0);
      run_phase(75, 0, 11'd1024, 11'd1024, 110, 50, 0);
      run_phase(0, 75, 11'd319, 11'd2047, 110, 50, 0);
      run_phase(26, 26, 11'd2047, 11'd0, 110, 50, 0);
      // A fractional ratio in both directions.
      run_phase(0, 0, 11'd330, 11'd205, 30, 55, 0);

      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- nearest_neighbor_frame_upscaler.f -----
sv/nnfu_pkg.sv
sv/nnfu_req_if.sv
sv/nnfu_rsp_if.sv
sv/nnfu_ram.sv
sv/nnfu_csr.sv
sv/nnfu_scan.sv
sv/nearest_neighbor_frame_upscaler.sv
dv/tb_top.sv
